// File: rtl/oflst_pkg.sv
// types, codes and control structs shared by the slot table modules
package oflst_pkg;

    localparam int unsigned CMD_W     = 3;
    localparam int unsigned SLOT_W    = 8;
    localparam int unsigned WORD_W    = 32;
    localparam int unsigned ST_W      = 2;
    localparam int unsigned CNT_OUT_W = 9;
    localparam int unsigned IN_W      = 48;
    localparam int unsigned OUT_W     = 64;
    localparam int unsigned OUT_PAD   = OUT_W - (ST_W + SLOT_W + WORD_W + 1 + 2 * CNT_OUT_W);

    typedef enum logic [CMD_W-1:0] {
        CMD_ALLOC   = 3'd0,
        CMD_RELEASE = 3'd1,
        CMD_LOOKUP  = 3'd2,
        CMD_REWIND  = 3'd3,
        CMD_NEXT    = 3'd4
    } t_cmd;

    typedef enum logic [ST_W-1:0] {
        ST_OK      = 2'd0,
        ST_INVALID = 2'd1,
        ST_FULL    = 2'd2,
        ST_ENDED   = 2'd3
    } t_status;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DECODE,
        S_AL_WAIT,
        S_RL_CHK,
        S_RL_WALK,
        S_RL_LINK,
        S_LK_CHK,
        S_NX_CHK,
        S_SK_TEST,
        S_SK_CHK,
        S_FIN
    } t_state;

    // read address source
    typedef enum logic [2:0] {
        RS_HEAD,
        RS_SLOT,
        RS_CURSOR,
        RS_PTR,
        RS_PTR_INC,
        RS_LINK
    } t_rsel;

    // write address and data source
    typedef enum logic [2:0] {
        WS_APPEND,
        WS_TAKE,
        WS_FRONT,
        WS_SPLICE,
        WS_LINK
    } t_wsel;

    typedef enum logic [1:0] {
        HD_KEEP,
        HD_APPEND,
        HD_LINK,
        HD_SLOT
    } t_hsel;

    typedef enum logic [2:0] {
        PT_KEEP,
        PT_ZERO,
        PT_HEAD,
        PT_LINK,
        PT_INC,
        PT_CURSOR_INC
    } t_psel;

    typedef enum logic [1:0] {
        CU_KEEP,
        CU_PTR,
        CU_PTR_INC
    } t_csel;

    typedef enum logic [1:0] {
        RO_KEEP,
        RO_MARK,
        RO_HEAD,
        RO_CURSOR
    } t_osel;

    typedef struct packed {
        logic    ld_in;
        logic    rd_en;
        t_rsel   rd_sel;
        logic    wr_en;
        t_wsel   wr_sel;
        t_hsel   head_op;
        t_psel   ptr_op;
        t_csel   cur_op;
        logic    mark_inc;
        logic    live_inc;
        logic    live_dec;
        logic    st_ld;
        t_status st_val;
        t_osel   rslot_op;
        logic    rword_ld;
        logic    occ_set;
        logic    out_ld;
    } t_ctl;

    typedef struct packed {
        logic [CMD_W-1:0] cmd;
        logic             head_lt_mark;
        logic             mark_full;
        logic             slot_lt_mark;
        logic             slot_lt_head;
        logic             cursor_lt_mark;
        logic             ptr_lt_mark;
        logic             ptr_inc_lt_mark;
        logic             rd_used;
        logic             link_stop;
        logic             out_free;
    } t_sts;

endpackage

// File: rtl/oflst_ctrl.sv
// sequencing state machine for the slot table operations
module oflst_ctrl
    import oflst_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    input  t_sts i_sts,
    output logic o_in_ready,
    output t_ctl o_ctl
);

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_state = S_DECODE;
                end
            end
            S_DECODE: begin
                case (t_cmd'(i_sts.cmd))
                    CMD_ALLOC:   n_state = i_sts.head_lt_mark ? S_AL_WAIT : S_FIN;
                    CMD_RELEASE: n_state = i_sts.slot_lt_mark ? S_RL_CHK : S_FIN;
                    CMD_LOOKUP:  n_state = i_sts.slot_lt_mark ? S_LK_CHK : S_FIN;
                    CMD_REWIND:  n_state = S_SK_TEST;
                    CMD_NEXT:    n_state = i_sts.cursor_lt_mark ? S_NX_CHK : S_FIN;
                    default:     n_state = S_FIN;
                endcase
            end
            S_AL_WAIT: n_state = S_FIN;
            S_RL_CHK: begin
                if (i_sts.rd_used && !i_sts.slot_lt_head) begin
                    n_state = S_RL_WALK;
                end else begin
                    n_state = S_FIN;
                end
            end
            S_RL_WALK: begin
                if (i_sts.link_stop) begin
                    n_state = S_RL_LINK;
                end
            end
            S_RL_LINK: n_state = S_FIN;
            S_LK_CHK:  n_state = S_FIN;
            S_NX_CHK:  n_state = S_SK_TEST;
            S_SK_TEST: n_state = i_sts.ptr_lt_mark ? S_SK_CHK : S_FIN;
            S_SK_CHK: begin
                if (i_sts.rd_used || !i_sts.ptr_inc_lt_mark) begin
                    n_state = S_FIN;
                end
            end
            S_FIN: begin
                if (i_sts.out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_ctl      = '0;
        o_in_ready = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_in_ready   = 1'b1;
                o_ctl.ld_in  = i_in_valid;
            end
            S_DECODE: begin
                case (t_cmd'(i_sts.cmd))
                    CMD_ALLOC: begin
                        if (i_sts.head_lt_mark) begin
                            o_ctl.rd_en  = 1'b1;
                            o_ctl.rd_sel = RS_HEAD;
                        end else if (!i_sts.mark_full) begin
                            o_ctl.wr_en    = 1'b1;
                            o_ctl.wr_sel   = WS_APPEND;
                            o_ctl.head_op  = HD_APPEND;
                            o_ctl.mark_inc = 1'b1;
                            o_ctl.live_inc = 1'b1;
                            o_ctl.rslot_op = RO_MARK;
                            o_ctl.st_ld    = 1'b1;
                            o_ctl.st_val   = ST_OK;
                        end else begin
                            o_ctl.st_ld  = 1'b1;
                            o_ctl.st_val = ST_FULL;
                        end
                    end
                    CMD_RELEASE, CMD_LOOKUP: begin
                        o_ctl.rd_en  = i_sts.slot_lt_mark;
                        o_ctl.rd_sel = RS_SLOT;
                    end
                    CMD_REWIND: begin
                        o_ctl.ptr_op = PT_ZERO;
                        o_ctl.st_ld  = 1'b1;
                        o_ctl.st_val = ST_OK;
                    end
                    CMD_NEXT: begin
                        if (i_sts.cursor_lt_mark) begin
                            o_ctl.rd_en  = 1'b1;
                            o_ctl.rd_sel = RS_CURSOR;
                        end else begin
                            o_ctl.st_ld  = 1'b1;
                            o_ctl.st_val = ST_ENDED;
                        end
                    end
                    default: ;
                endcase
            end
            S_AL_WAIT: begin
                o_ctl.wr_en    = 1'b1;
                o_ctl.wr_sel   = WS_TAKE;
                o_ctl.head_op  = HD_LINK;
                o_ctl.live_inc = 1'b1;
                o_ctl.rslot_op = RO_HEAD;
                o_ctl.st_ld    = 1'b1;
                o_ctl.st_val   = ST_OK;
            end
            S_RL_CHK: begin
                if (i_sts.rd_used) begin
                    o_ctl.live_dec = 1'b1;
                    o_ctl.occ_set  = 1'b1;
                    o_ctl.st_ld    = 1'b1;
                    o_ctl.st_val   = ST_OK;
                    if (i_sts.slot_lt_head) begin
                        o_ctl.wr_en   = 1'b1;
                        o_ctl.wr_sel  = WS_FRONT;
                        o_ctl.head_op = HD_SLOT;
                    end else begin
                        o_ctl.ptr_op = PT_HEAD;
                        o_ctl.rd_en  = 1'b1;
                        o_ctl.rd_sel = RS_HEAD;
                    end
                end
            end
            S_RL_WALK: begin
                if (i_sts.link_stop) begin
                    o_ctl.wr_en  = 1'b1;
                    o_ctl.wr_sel = WS_SPLICE;
                end else begin
                    o_ctl.ptr_op = PT_LINK;
                    o_ctl.rd_en  = 1'b1;
                    o_ctl.rd_sel = RS_LINK;
                end
            end
            S_RL_LINK: begin
                o_ctl.wr_en  = 1'b1;
                o_ctl.wr_sel = WS_LINK;
            end
            S_LK_CHK: begin
                if (i_sts.rd_used) begin
                    o_ctl.st_ld    = 1'b1;
                    o_ctl.st_val   = ST_OK;
                    o_ctl.occ_set  = 1'b1;
                    o_ctl.rword_ld = 1'b1;
                end
            end
            S_NX_CHK: begin
                o_ctl.st_ld  = 1'b1;
                o_ctl.ptr_op = PT_CURSOR_INC;
                if (i_sts.rd_used) begin
                    o_ctl.st_val   = ST_OK;
                    o_ctl.rslot_op = RO_CURSOR;
                    o_ctl.rword_ld = 1'b1;
                end else begin
                    o_ctl.st_val = ST_INVALID;
                end
            end
            S_SK_TEST: begin
                if (i_sts.ptr_lt_mark) begin
                    o_ctl.rd_en  = 1'b1;
                    o_ctl.rd_sel = RS_PTR;
                end else begin
                    o_ctl.cur_op = CU_PTR;
                end
            end
            S_SK_CHK: begin
                if (i_sts.rd_used) begin
                    o_ctl.cur_op = CU_PTR;
                end else if (i_sts.ptr_inc_lt_mark) begin
                    o_ctl.ptr_op = PT_INC;
                    o_ctl.rd_en  = 1'b1;
                    o_ctl.rd_sel = RS_PTR_INC;
                end else begin
                    o_ctl.cur_op = CU_PTR_INC;
                end
            end
            S_FIN: begin
                o_ctl.out_ld = i_sts.out_free;
            end
            default: ;
        endcase
    end

endmodule

// File: rtl/oflst_dp.sv
// slot store, chain registers, counters and result register
module oflst_dp
    import oflst_pkg::*;
#(
    parameter int unsigned SLOTS = 256,
    localparam int unsigned AW = $clog2(SLOTS),
    localparam int unsigned CW = $clog2(SLOTS + 1),
    localparam int unsigned SW = (CW > SLOT_W) ? CW : SLOT_W
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic [CMD_W-1:0]  i_cmd,
    input  logic [SLOT_W-1:0] i_slot,
    input  logic [WORD_W-1:0] i_payload,
    input  t_ctl              i_ctl,
    output t_sts              o_sts,
    input  logic              i_out_ready,
    output logic              o_out_valid,
    output logic [OUT_W-1:0]  o_out_data
);

    logic [CMD_W-1:0]  r_cmd;
    logic [SLOT_W-1:0] r_slot;
    logic [WORD_W-1:0] r_payload;
    logic [CW-1:0]     r_head;
    logic [CW-1:0]     r_live;
    logic [CW-1:0]     r_mark;
    logic [CW-1:0]     r_cursor;
    logic [CW-1:0]     r_ptr;

    logic [WORD_W:0]   r_mem [SLOTS];
    logic [WORD_W:0]   r_rd;

    t_status           r_st;
    logic [SLOT_W-1:0] r_rslot;
    logic [WORD_W-1:0] r_rword;
    logic              r_occ;
    logic              r_o_valid;
    logic [OUT_W-1:0]  r_o_data;

    logic [AW-1:0]     rd_addr;
    logic [AW-1:0]     wr_addr;
    logic [WORD_W:0]   wr_data;
    logic              rd_used;
    logic [WORD_W-1:0] rd_word;
    logic              link_beyond;
    logic [CW-1:0]     link;
    logic [CW-1:0]     link_clip;
    logic [CW-1:0]     ptr_inc;
    logic [CW-1:0]     cursor_inc;
    logic [CW-1:0]     mark_inc;
    logic              out_free;

    assign rd_used     = r_rd[WORD_W];
    assign rd_word     = r_rd[WORD_W-1:0];
    assign link_beyond = rd_word >= WORD_W'(r_mark);
    assign link        = CW'(rd_word);
    assign link_clip   = link_beyond ? r_mark : link;
    assign ptr_inc     = r_ptr + CW'(1);
    assign cursor_inc  = r_cursor + CW'(1);
    assign mark_inc    = r_mark + CW'(1);
    assign out_free    = !r_o_valid || i_out_ready;

    always_comb begin
        o_sts                 = '0;
        o_sts.cmd             = r_cmd;
        o_sts.head_lt_mark    = r_head < r_mark;
        o_sts.mark_full       = r_mark == CW'(SLOTS);
        o_sts.slot_lt_mark    = SW'(r_slot) < SW'(r_mark);
        o_sts.slot_lt_head    = SW'(r_slot) < SW'(r_head);
        o_sts.cursor_lt_mark  = r_cursor < r_mark;
        o_sts.ptr_lt_mark     = r_ptr < r_mark;
        o_sts.ptr_inc_lt_mark = ptr_inc < r_mark;
        o_sts.rd_used         = rd_used;
        o_sts.link_stop       = link_beyond || (rd_word > WORD_W'(r_slot));
        o_sts.out_free        = out_free;
    end

    always_comb begin
        case (i_ctl.rd_sel)
            RS_HEAD:    rd_addr = r_head[AW-1:0];
            RS_SLOT:    rd_addr = AW'(r_slot);
            RS_CURSOR:  rd_addr = r_cursor[AW-1:0];
            RS_PTR:     rd_addr = r_ptr[AW-1:0];
            RS_PTR_INC: rd_addr = ptr_inc[AW-1:0];
            RS_LINK:    rd_addr = link[AW-1:0];
            default:    rd_addr = r_ptr[AW-1:0];
        endcase
    end

    always_comb begin
        case (i_ctl.wr_sel)
            WS_APPEND: begin
                wr_addr = r_mark[AW-1:0];
                wr_data = {1'b1, r_payload};
            end
            WS_TAKE: begin
                wr_addr = r_head[AW-1:0];
                wr_data = {1'b1, r_payload};
            end
            WS_FRONT: begin
                wr_addr = AW'(r_slot);
                wr_data = {1'b0, WORD_W'(r_head)};
            end
            WS_SPLICE: begin
                wr_addr = AW'(r_slot);
                wr_data = {1'b0, WORD_W'(link_clip)};
            end
            WS_LINK: begin
                wr_addr = r_ptr[AW-1:0];
                wr_data = {1'b0, WORD_W'(r_slot)};
            end
            default: begin
                wr_addr = r_ptr[AW-1:0];
                wr_data = {1'b0, WORD_W'(r_slot)};
            end
        endcase
    end

    // entries below the high-water mark are always written before use
    always_ff @(posedge i_clk) begin
        if (i_ctl.wr_en) begin
            r_mem[wr_addr] <= wr_data;
        end
        if (i_ctl.rd_en) begin
            r_rd <= r_mem[rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.ld_in) begin
            r_cmd     <= i_cmd;
            r_slot    <= i_slot;
            r_payload <= i_payload;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head   <= '0;
            r_live   <= '0;
            r_mark   <= '0;
            r_cursor <= '0;
            r_ptr    <= '0;
        end else begin
            case (i_ctl.head_op)
                HD_APPEND: r_head <= mark_inc;
                HD_LINK:   r_head <= link;
                HD_SLOT:   r_head <= CW'(r_slot);
                default:   r_head <= r_head;
            endcase
            case (i_ctl.ptr_op)
                PT_ZERO:       r_ptr <= '0;
                PT_HEAD:       r_ptr <= r_head;
                PT_LINK:       r_ptr <= link;
                PT_INC:        r_ptr <= ptr_inc;
                PT_CURSOR_INC: r_ptr <= cursor_inc;
                default:       r_ptr <= r_ptr;
            endcase
            case (i_ctl.cur_op)
                CU_PTR:     r_cursor <= r_ptr;
                CU_PTR_INC: r_cursor <= ptr_inc;
                default:    r_cursor <= r_cursor;
            endcase
            if (i_ctl.mark_inc) begin
                r_mark <= mark_inc;
            end
            if (i_ctl.live_inc) begin
                r_live <= r_live + CW'(1);
            end else if (i_ctl.live_dec) begin
                r_live <= r_live - CW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.ld_in) begin
            r_st    <= ST_INVALID;
            r_rslot <= '0;
            r_rword <= '0;
            r_occ   <= 1'b0;
        end else begin
            if (i_ctl.st_ld) begin
                r_st <= i_ctl.st_val;
            end
            case (i_ctl.rslot_op)
                RO_MARK:   r_rslot <= SLOT_W'(r_mark);
                RO_HEAD:   r_rslot <= SLOT_W'(r_head);
                RO_CURSOR: r_rslot <= SLOT_W'(r_cursor);
                default:   r_rslot <= r_rslot;
            endcase
            if (i_ctl.rword_ld) begin
                r_rword <= rd_word;
            end
            if (i_ctl.occ_set) begin
                r_occ <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (i_ctl.out_ld) begin
            r_o_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_o_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.out_ld) begin
            r_o_data <= {{OUT_PAD{1'b0}}, CNT_OUT_W'(r_mark), CNT_OUT_W'(r_live), r_occ,
                         r_rword, r_rslot, r_st};
        end
    end

    assign o_out_valid = r_o_valid;
    assign o_out_data  = r_o_data;

    a_live_le_mark: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_live <= r_mark) else $error("occupied count above high-water mark");

    a_head_le_mark: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_head <= r_mark) else $error("free head beyond high-water mark");

    a_cursor_le_mark: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cursor <= r_mark) else $error("cursor beyond high-water mark");

    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_ctl.out_ld |-> out_free) else $error("result loaded over a waiting beat");

    a_mark_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_ctl.mark_inc |=> r_mark == $past(r_mark) + CW'(1))
        else $error("high-water mark did not advance by one");

endmodule

// File: rtl/ordered_free_list_slot_table_core.sv
// top level of the slot table with an ordered free chain
// allocate takes the free head if it lies below the mark, else appends at the mark; lookup reads the slot
// release puts a slot ahead of the head at the front of the chain, else walks the chain one link at a time
// rewind and next scan slot by slot for the next occupied one, up to the mark
// one beat at a time, the next one is taken in the cycle after the result is loaded
// sync active-low reset clears counters, free head and cursor; memory read only below the mark
module ordered_free_list_slot_table_core
    import oflst_pkg::*;
#(
    parameter int unsigned SLOTS = 256
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             s_axis_tvalid,
    output logic             s_axis_tready,
    input  logic [IN_W-1:0]  s_axis_tdata,   // command, slot, payload, zero fill
    output logic             m_axis_tvalid,
    input  logic             m_axis_tready,
    output logic [OUT_W-1:0] m_axis_tdata    // status, result_slot, result_payload,
                                             // occupied, used_count, high_water, zero fill
);

    t_ctl ctl;
    t_sts sts;

    oflst_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .i_sts      (sts),
        .o_in_ready (s_axis_tready),
        .o_ctl      (ctl)
    );

    oflst_dp #(
        .SLOTS (SLOTS)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (s_axis_tdata[CMD_W-1:0]),
        .i_slot      (s_axis_tdata[CMD_W+SLOT_W-1:CMD_W]),
        .i_payload   (s_axis_tdata[CMD_W+SLOT_W+WORD_W-1:CMD_W+SLOT_W]),
        .i_ctl       (ctl),
        .o_sts       (sts),
        .i_out_ready (m_axis_tready),
        .o_out_valid (m_axis_tvalid),
        .o_out_data  (m_axis_tdata)
    );

endmodule

// File: bench/testbench.sv
// self-checking bench for the ordered free-list slot table core
`timescale 1ns / 1ps

module testbench;
    import oflst_pkg::*;

    localparam int unsigned SLOTS = 256;
    localparam int unsigned RANDOM_PER_PHASE = 330;
    localparam int unsigned STALL_LIMIT = 4000;
    localparam int unsigned NUM_DIRECTED = 25;
    localparam int unsigned MAX_PRINTED = 40;

    localparam logic [CMD_W-1:0] CMD_BAD_LO = 3'd5;
    localparam logic [CMD_W-1:0] CMD_BAD_HI = 3'd7;

    localparam int unsigned O_SLOT = ST_W;
    localparam int unsigned O_WORD = O_SLOT + SLOT_W;
    localparam int unsigned O_OCC  = O_WORD + WORD_W;
    localparam int unsigned O_USED = O_OCC + 1;
    localparam int unsigned O_HW   = O_USED + CNT_OUT_W;

    typedef struct packed {
        t_status               status;
        logic [SLOT_W-1:0]     slot;
        logic [WORD_W-1:0]     word;
        logic                  occ;
        logic [CNT_OUT_W-1:0]  used;
        logic [CNT_OUT_W-1:0]  hw;
    } t_result;

    typedef struct packed {
        logic [CMD_W-1:0]  cmd;
        logic [SLOT_W-1:0] slot;
        logic [WORD_W-1:0] word;
        logic              typed;
        t_result           want;
    } t_row;

    typedef enum {
        MIX_FILL,
        MIX_DRAIN,
        MIX_MIXED,
        MIX_SCAN,
        MIX_NOISE
    } t_mix;

    localparam t_result NO_WANT = '{ST_OK, '0, '0, 1'b0, '0, '0};

    logic             i_clk;
    logic             i_rst_n;
    logic             s_axis_tvalid;
    logic             s_axis_tready;
    logic [IN_W-1:0]  s_axis_tdata;   // command, slot, payload, zero fill
    logic             m_axis_tvalid;
    logic             m_axis_tready;
    logic [OUT_W-1:0] m_axis_tdata;   // status, result_slot, result_payload,
                                      // occupied, used_count, high_water, zero fill

    ordered_free_list_slot_table_core #(
        .SLOTS(SLOTS)
    ) dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata (s_axis_tdata),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata (m_axis_tdata)
    );

    // table shadow
    bit                slot_used [SLOTS];
    logic [WORD_W-1:0] slot_word [SLOTS];
    int unsigned       chain_head;
    int unsigned       live_total;
    int unsigned       mark_total;
    int unsigned       scan_cursor;

    t_result     awaited_results [$];
    int unsigned tx_idle_pct;
    int unsigned rx_idle_pct;
    int unsigned fail_count;
    int unsigned beats_sent;
    int unsigned beats_checked;
    int unsigned phase_items;
    int unsigned status_seen [4];
    int unsigned peak_used;
    int unsigned stall_cycles;
    t_row        directed_rows [NUM_DIRECTED];

    always begin
        i_clk = 1'b0;
        #6;
        i_clk = 1'b1;
        #6;
    end

    task automatic flag_mismatch(string what, logic [OUT_W-1:0] got, logic [OUT_W-1:0] want);
        if (fail_count < MAX_PRINTED)
            $display("mismatch on result beat %0d: %s got %0h want %0h",
                     beats_checked, what, got, want);
        fail_count++;
    endtask

    // move the cursor to the first occupied slot at or after p
    function automatic void seek_cursor(int unsigned p);
        while (p < mark_total && !slot_used[p])
            p++;
        scan_cursor = p;
    endfunction

    function automatic bit free_slot(int unsigned s);
        int unsigned prev;
        int unsigned nxt;
        int unsigned hops;
        if (s >= mark_total || !slot_used[s])
            return 1'b0;
        slot_used[s] = 1'b0;
        live_total--;
        if (s < chain_head) begin
            slot_word[s] = chain_head;
            chain_head = s;
            return 1'b1;
        end
        prev = chain_head;
        for (hops = 0; hops < SLOTS; hops++) begin
            if (prev >= SLOTS)
                break;
            nxt = slot_word[prev];
            if (nxt >= mark_total || nxt > s) begin
                slot_word[s] = (nxt >= mark_total) ? mark_total : nxt;
                slot_word[prev] = s;
                return 1'b1;
            end
            prev = nxt;
        end
        slot_word[s] = mark_total;
        return 1'b1;
    endfunction

    function automatic t_result predict_table_op(logic [CMD_W-1:0] cmd, logic [SLOT_W-1:0] slot,
                                                 logic [WORD_W-1:0] word);
        t_result     r;
        int unsigned s;
        r = NO_WANT;
        r.status = ST_INVALID;
        case (cmd)
            CMD_ALLOC: begin
                s = SLOTS;
                if (chain_head < mark_total) begin
                    s = chain_head;
                    chain_head = slot_word[s];
                end else if (mark_total < SLOTS) begin
                    s = mark_total;
                    mark_total++;
                    chain_head = mark_total;
                end
                if (s < SLOTS) begin
                    slot_used[s] = 1'b1;
                    slot_word[s] = word;
                    live_total++;
                    r.status = ST_OK;
                    r.slot = SLOT_W'(s);
                end else begin
                    r.status = ST_FULL;
                end
            end
            CMD_RELEASE: begin
                if (free_slot(slot)) begin
                    r.status = ST_OK;
                    r.occ = 1'b1;
                end
            end
            CMD_LOOKUP: begin
                if (slot < mark_total && slot_used[slot]) begin
                    r.status = ST_OK;
                    r.occ = 1'b1;
                    r.word = slot_word[slot];
                end
            end
            CMD_REWIND: begin
                seek_cursor(0);
                r.status = ST_OK;
            end
            CMD_NEXT: begin
                if (scan_cursor >= mark_total) begin
                    r.status = ST_ENDED;
                end else if (!slot_used[scan_cursor]) begin
                    seek_cursor(scan_cursor + 1);
                end else begin
                    r.status = ST_OK;
                    r.slot = SLOT_W'(scan_cursor);
                    r.word = slot_word[scan_cursor];
                    seek_cursor(scan_cursor + 1);
                end
            end
            default: ;
        endcase
        r.used = CNT_OUT_W'(live_total);
        r.hw = CNT_OUT_W'(mark_total);
        if (live_total > peak_used)
            peak_used = live_total;
        return r;
    endfunction

    // mostly an occupied slot, sometimes any slot at all
    function automatic logic [SLOT_W-1:0] occupied_pick();
        int unsigned p;
        int unsigned n;
        if (live_total == 0 || $urandom_range(99) < 10)
            return SLOT_W'($urandom_range(SLOTS - 1));
        p = $urandom_range(mark_total - 1);
        for (n = 0; n < mark_total; n++) begin
            if (slot_used[p])
                return SLOT_W'(p);
            p = (p + 1 == mark_total) ? 0 : p + 1;
        end
        return SLOT_W'(p);
    endfunction

    task automatic drive_beat(logic [CMD_W-1:0] cmd, logic [SLOT_W-1:0] slot,
                              logic [WORD_W-1:0] word);
        @(negedge i_clk);
        while ($urandom_range(99) < tx_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(negedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= {{(IN_W - CMD_W - SLOT_W - WORD_W){1'b0}}, word, slot, cmd};
        do
            @(posedge i_clk);
        while (!s_axis_tready);
        beats_sent++;
        phase_items++;
    endtask

    task automatic issue(logic [CMD_W-1:0] cmd, logic [SLOT_W-1:0] slot,
                         logic [WORD_W-1:0] word);
        drive_beat(cmd, slot, word);
        awaited_results.push_back(predict_table_op(cmd, slot, word));
    endtask

    task automatic run_burst(t_mix mix, int unsigned len);
        logic [CMD_W-1:0]  cmd;
        logic [SLOT_W-1:0] slot;
        logic [WORD_W-1:0] word;
        int unsigned       roll;
        if (mix == MIX_SCAN)
            issue(CMD_REWIND, SLOT_W'($urandom_range(SLOTS - 1)), $urandom);
        repeat (len) begin
            roll = $urandom_range(99);
            word = $urandom;
            slot = occupied_pick();
            case (mix)
                MIX_FILL:
                    cmd = (roll < 75) ? CMD_ALLOC : (roll < 88) ? CMD_LOOKUP : CMD_RELEASE;
                MIX_DRAIN:
                    cmd = (roll < 70) ? CMD_RELEASE : (roll < 85) ? CMD_LOOKUP : CMD_ALLOC;
                MIX_MIXED:
                    cmd = (roll < 35) ? CMD_ALLOC : (roll < 65) ? CMD_RELEASE :
                          (roll < 85) ? CMD_LOOKUP : (roll < 92) ? CMD_REWIND : CMD_NEXT;
                MIX_SCAN: begin
                    // free the slot under the cursor now and then
                    if (roll < 15 && scan_cursor < mark_total && slot_used[scan_cursor]) begin
                        cmd = CMD_RELEASE;
                        slot = SLOT_W'(scan_cursor);
                    end else if (roll < 25) begin
                        cmd = CMD_ALLOC;
                    end else begin
                        cmd = CMD_NEXT;
                    end
                end
                default: begin
                    cmd = CMD_W'($urandom_range(CMD_BAD_HI));
                    slot = SLOT_W'($urandom_range(SLOTS - 1));
                end
            endcase
            issue(cmd, slot, word);
        end
    endtask

    task automatic run_random_phase();
        int unsigned roll;
        t_mix        mix;
        phase_items = 0;
        while (phase_items < RANDOM_PER_PHASE) begin
            roll = $urandom_range(99);
            mix = (roll < 25) ? MIX_FILL : (roll < 45) ? MIX_DRAIN : (roll < 70) ? MIX_MIXED :
                  (roll < 90) ? MIX_SCAN : MIX_NOISE;
            run_burst(mix, $urandom_range(40, 8));
        end
    endtask

    task automatic check_result(logic [OUT_W-1:0] d);
        t_result got;
        t_result want;
        got.status = t_status'(d[ST_W-1:0]);
        got.slot = d[O_SLOT +: SLOT_W];
        got.word = d[O_WORD +: WORD_W];
        got.occ = d[O_OCC];
        got.used = d[O_USED +: CNT_OUT_W];
        got.hw = d[O_HW +: CNT_OUT_W];
        if (awaited_results.size() == 0) begin
            flag_mismatch("unexpected result beat", d, '0);
        end else begin
            want = awaited_results.pop_front();
            if (got.status !== want.status)
                flag_mismatch("status", got.status, want.status);
            if (got.slot !== want.slot)
                flag_mismatch("result_slot", got.slot, want.slot);
            if (got.word !== want.word)
                flag_mismatch("result_payload", got.word, want.word);
            if (got.occ !== want.occ)
                flag_mismatch("occupied", got.occ, want.occ);
            if (got.used !== want.used)
                flag_mismatch("used_count", got.used, want.used);
            if (got.hw !== want.hw)
                flag_mismatch("high_water", got.hw, want.hw);
            status_seen[want.status]++;
        end
        beats_checked++;
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready)
            check_result(m_axis_tdata);
    end

    always @(negedge i_clk) begin
        if (i_rst_n)
            m_axis_tready <= ($urandom_range(99) >= rx_idle_pct);
    end

    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
        if (stall_cycles >= STALL_LIMIT) begin
            $display("watchdog: no beat moved for %0d cycles", stall_cycles);
            $display("ordered_free_list_slot_table_core test failed");
            $finish;
        end
    end

    initial begin
        int unsigned i;
        t_result     r;

        i_rst_n = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        m_axis_tready = 1'b0;
        stall_cycles = 0;
        fail_count = 0;
        beats_sent = 0;
        beats_checked = 0;
        peak_used = 0;
        status_seen = '{default: 0};
        slot_used = '{default: 1'b0};
        slot_word = '{default: '0};
        chain_head = 0;
        live_total = 0;
        mark_total = 0;
        scan_cursor = 0;
        tx_idle_pct = 23;
        rx_idle_pct = 53;

        directed_rows = '{
            '{CMD_LOOKUP,  8'd0,   32'h0,        1'b1, '{ST_INVALID, 8'd0, 32'h0, 1'b0, 9'd0, 9'd0}},
            '{CMD_NEXT,    8'd0,   32'h0,        1'b1, '{ST_ENDED,   8'd0, 32'h0, 1'b0, 9'd0, 9'd0}},
            '{CMD_RELEASE, 8'd255, 32'h0,        1'b1, '{ST_INVALID, 8'd0, 32'h0, 1'b0, 9'd0, 9'd0}},
            '{CMD_REWIND,  8'd0,   32'h0,        1'b1, '{ST_OK,      8'd0, 32'h0, 1'b0, 9'd0, 9'd0}},
            '{CMD_ALLOC,   8'd0,   32'hFFFFFFFF, 1'b1, '{ST_OK,      8'd0, 32'h0, 1'b0, 9'd1, 9'd1}},
            '{CMD_ALLOC,   8'd255, 32'h0,        1'b1, '{ST_OK,      8'd1, 32'h0, 1'b0, 9'd2, 9'd2}},
            '{CMD_ALLOC,   8'd0,   32'hA5A5A5A5, 1'b1, '{ST_OK,      8'd2, 32'h0, 1'b0, 9'd3, 9'd3}},
            '{CMD_ALLOC,   8'd0,   32'h5A5A5A5A, 1'b1, '{ST_OK,      8'd3, 32'h0, 1'b0, 9'd4, 9'd4}},
            '{CMD_LOOKUP,  8'd0,   32'h0,        1'b1,
              '{ST_OK, 8'd0, 32'hFFFFFFFF, 1'b1, 9'd4, 9'd4}},
            '{CMD_LOOKUP,  8'd255, 32'h0,        1'b1, '{ST_INVALID, 8'd0, 32'h0, 1'b0, 9'd4, 9'd4}},
            '{CMD_RELEASE, 8'd1,   32'h0,        1'b1, '{ST_OK,      8'd0, 32'h0, 1'b1, 9'd3, 9'd4}},
            '{CMD_RELEASE, 8'd1,   32'h0,        1'b1, '{ST_INVALID, 8'd0, 32'h0, 1'b0, 9'd3, 9'd4}},
            '{CMD_LOOKUP,  8'd1,   32'h0,        1'b1, '{ST_INVALID, 8'd0, 32'h0, 1'b0, 9'd3, 9'd4}},
            '{CMD_RELEASE, 8'd3,   32'h0,        1'b0, NO_WANT},
            '{CMD_REWIND,  8'd0,   32'h0,        1'b0, NO_WANT},
            '{CMD_NEXT,    8'd0,   32'h0,        1'b0, NO_WANT},
            '{CMD_RELEASE, 8'd2,   32'h0,        1'b0, NO_WANT},
            '{CMD_NEXT,    8'd0,   32'h0,        1'b0, NO_WANT},
            '{CMD_NEXT,    8'd0,   32'h0,        1'b0, NO_WANT},
            '{CMD_ALLOC,   8'd0,   32'h12345678, 1'b0, NO_WANT},
            '{CMD_ALLOC,   8'd0,   32'h87654321, 1'b0, NO_WANT},
            '{CMD_BAD_LO,  8'd0,   32'h0,        1'b0, NO_WANT},
            '{CMD_BAD_HI,  8'd255, 32'hFFFFFFFF, 1'b0, NO_WANT},
            '{CMD_RELEASE, 8'd0,   32'h0,        1'b0, NO_WANT},
            '{CMD_LOOKUP,  8'd2,   32'h0,        1'b0, NO_WANT}
        };

        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        for (i = 0; i < NUM_DIRECTED; i++) begin
            drive_beat(directed_rows[i].cmd, directed_rows[i].slot, directed_rows[i].word);
            r = predict_table_op(directed_rows[i].cmd, directed_rows[i].slot,
                                 directed_rows[i].word);
            awaited_results.push_back(directed_rows[i].typed ? directed_rows[i].want : r);
        end

        // fill the table, then push past full
        while (live_total < SLOTS)
            issue(CMD_ALLOC, SLOT_W'($urandom_range(SLOTS - 1)), $urandom);
        repeat (3)
            issue(CMD_ALLOC, SLOT_W'($urandom_range(SLOTS - 1)), $urandom);
        run_burst(MIX_SCAN, 12);
        run_random_phase();

        tx_idle_pct = 53;
        rx_idle_pct = 23;
        run_random_phase();

        tx_idle_pct = 0;
        rx_idle_pct = 0;
        run_random_phase();

        @(negedge i_clk);
        s_axis_tvalid <= 1'b0;
        while (awaited_results.size() != 0)
            @(posedge i_clk);
        repeat (SLOTS + 8) @(posedge i_clk);
        if (awaited_results.size() != 0)
            flag_mismatch("results never delivered", awaited_results.size(), '0);

        $display("%0d command beats sent, %0d result beats checked, %0d mismatches",
                 beats_sent, beats_checked, fail_count);
        $display("status mix ok %0d invalid %0d full %0d ended %0d, peak occupancy %0d",
                 status_seen[ST_OK], status_seen[ST_INVALID], status_seen[ST_FULL],
                 status_seen[ST_ENDED], peak_used);
        if (fail_count == 0)
            $display("ordered_free_list_slot_table_core test passed");
        else
            $display("ordered_free_list_slot_table_core test failed");
        $finish;
    end

endmodule
